// File: hdl/tea_pkg.sv
// ----------------------------------------------------------------------------
// tea_pkg: shared types, constants and functions of the TEA cipher core
// Round count, delta, block and configuration types, and the round mix.
// ----------------------------------------------------------------------------
package tea_pkg;

  localparam int unsigned WORD_W      = 32;
  localparam int unsigned ROUND_COUNT = 32;
  localparam int unsigned NUM_STAGES  = 2 * ROUND_COUNT;
  localparam int unsigned CFG_IDX_W   = 3;

  localparam logic [WORD_W-1:0] TEA_DELTA = 32'h9E3779B9;

  // Encrypt or decrypt
  typedef enum logic {
    DIR_ENCRYPT = 1'b0,
    DIR_DECRYPT = 1'b1
  } dir_e;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_DIRECTION = 3'd0,
    CFG_KEY_WORD0 = 3'd1,
    CFG_KEY_WORD1 = 3'd2,
    CFG_KEY_WORD2 = 3'd3,
    CFG_KEY_WORD3 = 3'd4
  } cfg_idx_e;

  // One 64-bit block as two halves
  typedef struct packed {
    logic [WORD_W-1:0] v0;
    logic [WORD_W-1:0] v1;
  } blk_t;

  // Current cipher setup, shared by all stages
  typedef struct packed {
    dir_e              dir;
    logic [WORD_W-1:0] k0;
    logic [WORD_W-1:0] k1;
    logic [WORD_W-1:0] k2;
    logic [WORD_W-1:0] k3;
  } cfg_t;

  // TEA half-round function
  function automatic logic [WORD_W-1:0] mix_half(
    input logic [WORD_W-1:0] x,
    input logic [WORD_W-1:0] sum,
    input logic [WORD_W-1:0] ka,
    input logic [WORD_W-1:0] kb
  );
    return ((x << 4) + ka) ^ (x + sum) ^ ((x >> 5) + kb);
  endfunction

endpackage

// File: hdl/tea_in_if.sv
// ----------------------------------------------------------------------------
// tea_in_if: input block channel
// Valid/ready channel carrying one plaintext or ciphertext block per beat.
// ----------------------------------------------------------------------------
interface tea_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] text_left;
  logic [31:0] text_right;

  modport source (output valid, output text_left, output text_right, input ready);
  modport sink   (input valid, input text_left, input text_right, output ready);
endinterface

// File: hdl/tea_out_if.sv
// ----------------------------------------------------------------------------
// tea_out_if: result block channel
// Valid/ready channel carrying one transformed block per beat.
// ----------------------------------------------------------------------------
interface tea_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] out_left;
  logic [31:0] out_right;

  modport source (output valid, output out_left, output out_right, input ready);
  modport sink   (input valid, input out_left, input out_right, output ready);
endinterface

// File: hdl/tea_stage.sv
// ----------------------------------------------------------------------------
// tea_stage: one half-round pipeline stage
// Applies one TEA half-round to the block and registers it with its valid bit.
// ----------------------------------------------------------------------------
module tea_stage
  import tea_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  cfg_t              cfg_i,
  input  logic [WORD_W-1:0] sum_i,
  input  logic              second_i,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  blk_t              in_blk_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output blk_t              out_blk_o
);

  logic              valid_q;
  blk_t              blk_q, blk_d;
  logic              upd_left;
  logic [WORD_W-1:0] src, ka, kb, mix, dst, res;

  // Pick the half to update: encrypt does left then right, decrypt right then left
  assign upd_left = (cfg_i.dir == DIR_ENCRYPT) ? !second_i : second_i;

  always_comb begin
    src = upd_left ? in_blk_i.v1 : in_blk_i.v0;
    dst = upd_left ? in_blk_i.v0 : in_blk_i.v1;
    ka  = upd_left ? cfg_i.k0 : cfg_i.k2;
    kb  = upd_left ? cfg_i.k1 : cfg_i.k3;
    mix = mix_half(src, sum_i, ka, kb);
    res = (cfg_i.dir == DIR_ENCRYPT) ? dst + mix : dst - mix;
    blk_d = in_blk_i;
    if (upd_left) begin
      blk_d.v0 = res;
    end else begin
      blk_d.v1 = res;
    end
  end

  // Slot is free when empty or when its beat moves on
  assign in_ready_o = !valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_ready_o) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      blk_q <= blk_d;
    end
  end

  assign out_valid_o = valid_q;
  assign out_blk_o   = blk_q;

endmodule

// File: hdl/tea_block_cipher_core.sv
// ----------------------------------------------------------------------------
// tea_block_cipher_core: pipelined TEA block cipher, ECB, 32 rounds
// Pipeline: one registered stage per half-round between input beat and result beat.
// Throughput: one block per cycle; a stalled output holds the pipeline while
// empty stages still take new beats.
// Reset: clears all stage valid bits, direction (encrypt) and the key to zero.
// ----------------------------------------------------------------------------
module tea_block_cipher_core
  import tea_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [WORD_W-1:0]    cfg_wdata_i,
  tea_in_if.sink               in_if,
  tea_out_if.source            out_if
);

  cfg_t              cfg_q;
  logic              vld   [NUM_STAGES+1];
  logic              rdy   [NUM_STAGES+1];
  blk_t              blk   [NUM_STAGES+1];

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.dir <= DIR_ENCRYPT;
      cfg_q.k0  <= '0;
      cfg_q.k1  <= '0;
      cfg_q.k2  <= '0;
      cfg_q.k3  <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_DIRECTION: cfg_q.dir <= dir_e'(cfg_wdata_i[0]);
        CFG_KEY_WORD0: cfg_q.k0  <= cfg_wdata_i;
        CFG_KEY_WORD1: cfg_q.k1  <= cfg_wdata_i;
        CFG_KEY_WORD2: cfg_q.k2  <= cfg_wdata_i;
        CFG_KEY_WORD3: cfg_q.k3  <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // Pipeline head
  assign vld[0]      = in_if.valid;
  assign in_if.ready = rdy[0];
  assign blk[0].v0   = in_if.text_left;
  assign blk[0].v1   = in_if.text_right;

  // Half-round stages, two per round with a shared round sum
  for (genvar s = 0; s < NUM_STAGES; s++) begin : g_stage
    localparam int unsigned  RND     = s / 2;
    localparam logic [63:0]  ENC_W   = 64'(TEA_DELTA) * 64'(RND + 1);
    localparam logic [63:0]  DEC_W   = 64'(TEA_DELTA) * 64'(ROUND_COUNT - RND);
    localparam logic [WORD_W-1:0] SUM_ENC = ENC_W[WORD_W-1:0];
    localparam logic [WORD_W-1:0] SUM_DEC = DEC_W[WORD_W-1:0];
    localparam logic         SECOND  = 1'((s % 2) == 1);

    logic [WORD_W-1:0] sum;
    assign sum = (cfg_q.dir == DIR_ENCRYPT) ? SUM_ENC : SUM_DEC;

    tea_stage u_stage (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .cfg_i       (cfg_q),
      .sum_i       (sum),
      .second_i    (SECOND),
      .in_valid_i  (vld[s]),
      .in_ready_o  (rdy[s]),
      .in_blk_i    (blk[s]),
      .out_valid_o (vld[s+1]),
      .out_ready_i (rdy[s+1]),
      .out_blk_o   (blk[s+1])
    );
  end

  // Last stage is the output register
  assign rdy[NUM_STAGES] = out_if.ready;
  assign out_if.valid    = vld[NUM_STAGES];
  assign out_if.out_left  = blk[NUM_STAGES].v0;
  assign out_if.out_right = blk[NUM_STAGES].v1;

endmodule

// File: sim/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the pipelined TEA block cipher core
// Blocks are queued by a stimulus sequence and offered by a clocked driver on
// the input channel. A clocked monitor checks every result beat against a
// local TEA model evaluated with the key and direction at input acceptance.
// Covers directed corner blocks and register cases, then random blocks under
// many key setups with both sides idling at varying rates and a long output
// stall.
// ----------------------------------------------------------------------------
module tb_top
  import tea_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  localparam realtime HALF_PERIOD   = 4ns;
  localparam int      CYCLE_LIMIT   = 200000;
  localparam int      LONG_HOLD     = 400;
  localparam int      MAX_REPORTS   = 10;
  localparam int      PHASE_BLOCKS  = 360;
  localparam int      FLOOD_BLOCKS  = 200;
  localparam int      SETTLE_CYCLES = NUM_STAGES + 16;

  // Register indexes with no register behind them
  localparam logic [CFG_IDX_W-1:0] SPARE_IDX_FIRST = 3'd5;
  localparam logic [CFG_IDX_W-1:0] SPARE_IDX_LAST  = 3'd7;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  // Configuration port
  logic                 cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx   = '0;
  logic [WORD_W-1:0]    cfg_wdata = '0;

  // Input driver and output sink state
  logic src_valid = 1'b0;
  blk_t src_blk   = '0;
  logic snk_ready = 1'b0;

  int src_idle_pct = 0;
  int snk_idle_pct = 0;

  // Long output stall, served by its own process
  int hold_requests = 0;
  int hold_served   = 0;
  int hold_left     = 0;

  // Cipher setup as the core should hold it
  cfg_t key_setup = '0;

  blk_t pending_q [$];
  blk_t cipher_q  [$];

  int blocks_in   = 0;
  int results_out = 0;
  int setups      = 0;
  int err_cnt     = 0;
  int cycle_cnt   = 0;

  tea_in_if  in_ch ();
  tea_out_if out_ch ();

  assign in_ch.valid      = src_valid;
  assign in_ch.text_left  = src_blk.v0;
  assign in_ch.text_right = src_blk.v1;
  assign out_ch.ready     = snk_ready;

  tea_block_cipher_core uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_wdata_i (cfg_wdata),
    .in_if       (in_ch),
    .out_if      (out_ch)
  );

  always #HALF_PERIOD clk_i = ~clk_i;

  // TEA Feistel mix of one half with the running sum and two key words
  function automatic logic [WORD_W-1:0] feistel_mix(
    input logic [WORD_W-1:0] x,
    input logic [WORD_W-1:0] sum,
    input logic [WORD_W-1:0] ka,
    input logic [WORD_W-1:0] kb
  );
    logic [WORD_W-1:0] shl;
    logic [WORD_W-1:0] shr;
    shl = {x[WORD_W-5:0], 4'b0000};
    shr = {5'b00000, x[WORD_W-1:5]};
    return (shl + ka) ^ (x + sum) ^ (shr + kb);
  endfunction

  // Full TEA transform of one block under the given setup
  function automatic blk_t tea_cipher_block(input blk_t b, input cfg_t c);
    logic [WORD_W-1:0] v0;
    logic [WORD_W-1:0] v1;
    logic [WORD_W-1:0] sum;
    v0 = b.v0;
    v1 = b.v1;
    if (c.dir == DIR_ENCRYPT) begin
      sum = '0;
      for (int r = 0; r < ROUND_COUNT; r++) begin
        sum = sum + TEA_DELTA;
        v0  = v0 + feistel_mix(v1, sum, c.k0, c.k1);
        v1  = v1 + feistel_mix(v0, sum, c.k2, c.k3);
      end
    end else begin
      sum = TEA_DELTA * ROUND_COUNT;
      for (int r = 0; r < ROUND_COUNT; r++) begin
        v1  = v1 - feistel_mix(v0, sum, c.k2, c.k3);
        v0  = v0 - feistel_mix(v1, sum, c.k0, c.k1);
        sum = sum - TEA_DELTA;
      end
    end
    return '{v0: v0, v1: v1};
  endfunction

  // Random word, biased toward all-zero, all-one and single-bit patterns
  function automatic logic [WORD_W-1:0] rand_word();
    logic [WORD_W-1:0] onehot;
    onehot = 32'h1 << $urandom_range(WORD_W - 1);
    case ($urandom_range(9))
      0:       return '0;
      1:       return '1;
      2:       return onehot;
      3:       return ~onehot;
      default: return $urandom();
    endcase
  endfunction

  task automatic report_error(input string msg);
    err_cnt++;
    if (err_cnt <= MAX_REPORTS) $display("ERROR @%0t: %s", $realtime, msg);
  endtask

  // One register write; the setup copy follows what the core should keep
  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [WORD_W-1:0] data);
    @(posedge clk_i);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= data;
    case (idx)
      CFG_DIRECTION: key_setup.dir = dir_e'(data[0]);
      CFG_KEY_WORD0: key_setup.k0  = data;
      CFG_KEY_WORD1: key_setup.k1  = data;
      CFG_KEY_WORD2: key_setup.k2  = data;
      CFG_KEY_WORD3: key_setup.k3  = data;
      default: ;  // unused index, nothing changes
    endcase
    @(posedge clk_i);
    cfg_we <= 1'b0;
  endtask

  task automatic load_setup(
    input dir_e              d,
    input logic [WORD_W-1:0] k0,
    input logic [WORD_W-1:0] k1,
    input logic [WORD_W-1:0] k2,
    input logic [WORD_W-1:0] k3
  );
    cfg_write(CFG_DIRECTION, {{(WORD_W-1){1'b0}}, d});
    cfg_write(CFG_KEY_WORD0, k0);
    cfg_write(CFG_KEY_WORD1, k1);
    cfg_write(CFG_KEY_WORD2, k2);
    cfg_write(CFG_KEY_WORD3, k3);
    setups++;
  endtask

  // Pause until nothing is queued, offered or in flight
  task automatic wait_drained();
    do @(negedge clk_i);
    while (pending_q.size() != 0 || src_valid || cipher_q.size() != 0);
  endtask

  // Input driver: holds a beat until accepted, then maybe loads the next
  always @(posedge clk_i) begin : drive_blocks
    blk_t nxt_blk;
    logic nxt_valid;
    if (!rst_ni) begin
      src_valid <= 1'b0;
      src_blk   <= '0;
    end else begin
      nxt_valid = src_valid;
      nxt_blk   = src_blk;
      if (src_valid && in_ch.ready) begin
        cipher_q.push_back(tea_cipher_block(src_blk, key_setup));
        blocks_in++;
        nxt_valid = 1'b0;
      end
      if (!nxt_valid && pending_q.size() != 0 && $urandom_range(99) >= src_idle_pct) begin
        nxt_blk   = pending_q.pop_front();
        nxt_valid = 1'b1;
      end
      src_valid <= nxt_valid;
      src_blk   <= nxt_blk;
    end
  end

  // Long output stall counter
  always @(posedge clk_i) begin
    if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end else if (hold_served != hold_requests) begin
      hold_left   <= LONG_HOLD;
      hold_served <= hold_served + 1;
    end
  end

  // Result monitor: compares each result beat with the oldest expected block
  always @(posedge clk_i) begin : check_results
    blk_t want;
    if (!rst_ni) begin
      snk_ready <= 1'b0;
    end else begin
      if (out_ch.valid && snk_ready) begin
        results_out++;
        if (cipher_q.size() == 0) begin
          report_error($sformatf("unexpected result %h_%h",
                                 out_ch.out_left, out_ch.out_right));
        end else begin
          want = cipher_q.pop_front();
          if (out_ch.out_left !== want.v0)
            report_error($sformatf("result %0d out_left: expected %h, got %h",
                                   results_out, want.v0, out_ch.out_left));
          if (out_ch.out_right !== want.v1)
            report_error($sformatf("result %0d out_right: expected %h, got %h",
                                   results_out, want.v1, out_ch.out_right));
        end
      end
      snk_ready <= (hold_left == 0) && ($urandom_range(99) >= snk_idle_pct);
    end
  end

  // Watchdog
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d results still due", cycle_cnt, cipher_q.size());
      $display("Simulation FAILED");
      $finish;
    end
  end

  // Stimulus sequence
  initial begin : stimulus
    blk_t corner_blks [6];
    int   phase_blocks;
    int   n;
    corner_blks = '{
      '{v0: 32'h0000_0000, v1: 32'h0000_0000},
      '{v0: 32'hFFFF_FFFF, v1: 32'hFFFF_FFFF},
      '{v0: 32'h0000_0000, v1: 32'hFFFF_FFFF},
      '{v0: 32'hFFFF_FFFF, v1: 32'h0000_0000},
      '{v0: 32'h8000_0000, v1: 32'h0000_0001},
      '{v0: 32'h0000_0001, v1: 32'h8000_0000}
    };

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Corner blocks under the reset setup: encrypt, all-zero key
    @(negedge clk_i);
    foreach (corner_blks[i]) pending_q.push_back(corner_blks[i]);
    wait_drained();

    // Decrypt with an all-ones key
    load_setup(DIR_DECRYPT, '1, '1, '1, '1);
    @(negedge clk_i);
    foreach (corner_blks[i]) pending_q.push_back(corner_blks[i]);
    wait_drained();

    // Unused indexes are ignored; a wide direction write keeps bit 0 only
    for (int i = SPARE_IDX_FIRST; i <= SPARE_IDX_LAST; i++)
      cfg_write(CFG_IDX_W'(i), $urandom());
    cfg_write(CFG_DIRECTION, 32'hFFFF_FFFE);
    @(negedge clk_i);
    pending_q.push_back(corner_blks[0]);
    pending_q.push_back(corner_blks[1]);
    wait_drained();
    cfg_write(CFG_DIRECTION, 32'h8000_0001);
    @(negedge clk_i);
    pending_q.push_back(corner_blks[4]);
    pending_q.push_back(corner_blks[5]);
    wait_drained();

    // Random blocks in three idling regimes, new setup per burst
    for (int ph = 0; ph < 3; ph++) begin
      @(negedge clk_i);
      case (ph)
        0: begin src_idle_pct = 26; snk_idle_pct = 78; end
        1: begin src_idle_pct = 78; snk_idle_pct = 26; end
        default: begin src_idle_pct = 0; snk_idle_pct = 0; end
      endcase
      phase_blocks = 0;
      while (phase_blocks < PHASE_BLOCKS) begin
        load_setup(dir_e'($urandom_range(1)), rand_word(), rand_word(), rand_word(),
                   rand_word());
        @(negedge clk_i);
        // First burst floods the core behind a long output stall
        if (ph == 0 && phase_blocks == 0) begin
          hold_requests++;
          n = FLOOD_BLOCKS;
        end else begin
          n = $urandom_range(16, 64);
        end
        repeat (n) pending_q.push_back('{v0: rand_word(), v1: rand_word()});
        phase_blocks += n;
        wait_drained();
      end
    end

    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (cipher_q.size() != 0)
      report_error($sformatf("%0d results never arrived", cipher_q.size()));

    $display("Run: %0d blocks in, %0d results out, %0d key setups, both directions",
             blocks_in, results_out, setups);
    $display("Idling regimes 26/78, 78/26 and none; %0d-cycle output stall; %0d errors",
             LONG_HOLD, err_cnt);
    if (err_cnt == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
